// ===== hw/rtl/gbsp_pkg.sv =====
// Package for the grid shortest-path block: grid limits, cell types, direction codes
// and the command and status structs between the controller and the datapath.
// No dependencies.
`timescale 1ns / 1ps
package gbsp_pkg;

   localparam int MaxCells = 63;
   localparam int CellW = 6;
   localparam int CodeW = 7;

   typedef logic [CellW-1:0] cell_type;
   typedef logic [CodeW-1:0] code_type;

   typedef enum logic [1:0] {
      DIR_UP    = 2'd0,
      DIR_DOWN  = 2'd1,
      DIR_LEFT  = 2'd2,
      DIR_RIGHT = 2'd3
   } dir_type;

   typedef struct packed {
      logic load;      // latch the query and clear the visited bits
      logic pop;       // take the queue head as the current cell
      logic expand;    // try the neighbor in direction dir
      dir_type dir;
      logic trace;     // step from cur toward start, push cur
      logic push_start;
      logic emit;      // load output register from the stack top
   } cmd_type;

   typedef struct packed {
      logic valid_q;   // both codes name cells
      logic q_empty;   // head reached tail
      logic at_target; // current cell is the target
      logic at_start;  // trace pointer is the start
      logic stack_one; // exactly one entry left on the stack
      logic trace_full;
   } sts_type;

endpackage

// ===== hw/rtl/grid_bfs_shortest_path.sv =====
// Top level of the grid breadth-first shortest-path block: configuration register,
// controller and datapath. Depends on gbsp_pkg, gbsp_ctrl and gbsp_datapath.
//
// Channel  Direction  Payload
// req_     in         tdata[6:0] start_code, tdata[13:7] target_code
// rsp_     out        tdata[6:0] cell_code, tuser path_found, tlast last_cell
// csr_     in         data[62:0] blocked_mask
//
// A query checks the codes, then for each dequeued cell pops it, tests it and tries its
// four neighbors; on reaching the target it traces back, pushing each path cell, then
// pushes the start and emits one output beat per stack entry before returning to idle. The
// expansion loop tries one neighbor per cycle. Reset is synchronous and clears control
// state and the mask. A stalled rsp_ beat holds the output sequence; req_tready is low
// from acceptance until the last beat of the query is taken.
`timescale 1ns / 1ps
module grid_bfs_shortest_path
   import gbsp_pkg::*;
#(
   parameter int ROWS = 9,
   parameter int COLS = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [6:0] start_code, [13:7] target_code
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [6:0] cell_code
   output logic        rsp_tuser,   // [0] path_found
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [62:0] csr_data
);

   logic [62:0] mask_ff;
   cmd_type     cmd;
   sts_type     sts;
   code_type    out_code;
   logic        found, busy;

   // The mask is only written while the block is idle.
   assign csr_ready = !busy;

   always_ff @(posedge clock) begin
      if (reset) mask_ff <= '0;
      else if (csr_valid && csr_ready) mask_ff <= csr_data;
   end

   gbsp_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_found(found), .rsp_last(rsp_tlast), .busy(busy),
      .sts(sts), .cmd(cmd)
   );

   gbsp_datapath #(.ROWS(ROWS), .COLS(COLS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .start_code(req_tdata[6:0]), .target_code(req_tdata[13:7]),
      .blocked(mask_ff), .sts(sts), .out_code(out_code)
   );

   // Not-found beats carry a zero code.
   assign rsp_tdata = {1'b0, found ? out_code : 7'd0};
   assign rsp_tuser = found;

`ifndef SYNTHESIS
   a_not_ready_busy: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("ready while beat pending");
   a_nf_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tlast && rsp_tdata == 8'd0))
      else $error("bad not-found beat");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> busy) else $error("not busy after accept");
`endif

endmodule

// ===== hw/rtl/gbsp_datapath.sv =====
// Datapath of the grid shortest-path block: visited bits, parent store, queue,
// path stack and the code conversion. Uses gbsp_pkg.
`timescale 1ns / 1ps
module gbsp_datapath
   import gbsp_pkg::*;
#(
   parameter int ROWS = 9,
   parameter int COLS = 7
) (
   input  logic          clock,
   input  logic          reset,
   input  cmd_type       cmd,
   input  code_type      start_code,
   input  code_type      target_code,
   input  logic [62:0]   blocked,
   output sts_type       sts,
   output code_type      out_code
);

   localparam int NCells = ROWS * COLS;

   logic [NCells-1:0] visited_ff, visited_in;
   logic [1:0]        parent_mem [NCells];
   cell_type          queue_mem  [NCells];
   code_type          stack_mem  [NCells];
   cell_type          start_ff, target_ff, cur_ff, cur_in;
   cell_type          q_rd_ff;
   cell_type          start_cell, target_cell;
   code_type          start_code_ff;
   code_type          cur_code;
   logic              valid_ff;
   logic [3:0]        cur_r_ff, cur_c_ff, cur_r_in, cur_c_in;
   logic [CellW:0]    head_ff, tail_ff, len_ff;
   logic [CellW:0]    head_in, tail_in, len_in;
   logic [3:0]        nr, nc;
   logic              nb_ok;
   cell_type          nb;
   logic [1:0]        pdir_ff;
   logic [7:0]        pop_rc;
   logic [3:0]        sr, sc, tr, tc;
   logic              sok, tok;

   // Decimal code to row and column; tens and units digits are narrow, so a compare chain.
   function automatic logic [7:0] split(input code_type code);
      logic [3:0] t;
      logic [6:0] u;
      t = 4'd0;
      u = code;
      if (code >= 7'd90) begin t = 4'd9; u = code - 7'd90; end
      else if (code >= 7'd80) begin t = 4'd8; u = code - 7'd80; end
      else if (code >= 7'd70) begin t = 4'd7; u = code - 7'd70; end
      else if (code >= 7'd60) begin t = 4'd6; u = code - 7'd60; end
      else if (code >= 7'd50) begin t = 4'd5; u = code - 7'd50; end
      else if (code >= 7'd40) begin t = 4'd4; u = code - 7'd40; end
      else if (code >= 7'd30) begin t = 4'd3; u = code - 7'd30; end
      else if (code >= 7'd20) begin t = 4'd2; u = code - 7'd20; end
      else if (code >= 7'd10) begin t = 4'd1; u = code - 7'd10; end
      if (code >= 7'd100) t = 4'd15;
      return {t, u[3:0]};
   endfunction

   // Cell index to row and column by comparing against the first index of each row.
   function automatic logic [7:0] cell_rc(input cell_type idx);
      logic [3:0] r;
      cell_type   base;
      r = 4'd0;
      base = '0;
      for (int i = 1; i < ROWS; i++) begin
         if (idx >= CellW'(i * COLS)) begin
            r = 4'(i);
            base = CellW'(i * COLS);
         end
      end
      return {r, 4'(idx - base)};
   endfunction

   always_comb begin
      {tr, tc} = split(target_code);
      {sr, sc} = split(start_code);
      sok = (sr != 4'd0) && (sr <= 4'(ROWS)) && (sc != 4'd0) && (sc <= 4'(COLS));
      tok = (tr != 4'd0) && (tr <= 4'(ROWS)) && (tc != 4'd0) && (tc <= 4'(COLS));
      start_cell = CellW'(sr - 4'd1) * CellW'(COLS) + CellW'(sc - 4'd1);
      target_cell = CellW'(tr - 4'd1) * CellW'(COLS) + CellW'(tc - 4'd1);
   end

   always_comb begin
      nr = cur_r_ff;
      nc = cur_c_ff;
      nb_ok = 1'b1;
      case (cmd.dir)
         DIR_UP: begin
            nb_ok = (cur_r_ff != 4'd0);
            nr = cur_r_ff - 4'd1;
         end
         DIR_DOWN: begin
            nb_ok = (cur_r_ff != 4'(ROWS - 1));
            nr = cur_r_ff + 4'd1;
         end
         DIR_LEFT: begin
            nb_ok = (cur_c_ff != 4'd0);
            nc = cur_c_ff - 4'd1;
         end
         default: begin
            nb_ok = (cur_c_ff != 4'(COLS - 1));
            nc = cur_c_ff + 4'd1;
         end
      endcase
      nb = CellW'(nr) * CellW'(COLS) + CellW'(nc);
      if (nb_ok) nb_ok = !blocked[nb] && !visited_ff[nb] && (tail_ff < 7'(NCells));
   end

   assign pop_rc = cell_rc(q_rd_ff);
   assign cur_code = 7'(cur_r_ff) * 7'd10 + 7'(cur_c_ff) + 7'd11;

   always_comb begin
      visited_in = visited_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      len_in = len_ff;
      cur_in = cur_ff;
      cur_r_in = cur_r_ff;
      cur_c_in = cur_c_ff;
      if (cmd.load) begin
         visited_in = '0;
         visited_in[start_cell] = 1'b1;
         head_in = '0;
         tail_in = 7'd1;
         len_in = '0;
      end
      if (cmd.pop) begin
         cur_in = q_rd_ff;
         cur_r_in = pop_rc[7:4];
         cur_c_in = pop_rc[3:0];
         head_in = head_ff + 7'd1;
      end
      if (cmd.expand && nb_ok) begin
         visited_in[nb] = 1'b1;
         tail_in = tail_ff + 7'd1;
      end
      if (cmd.trace) begin
         len_in = len_ff + 7'd1;
         case (pdir_ff)
            DIR_UP:   cur_r_in = cur_r_ff + 4'd1;
            DIR_DOWN: cur_r_in = cur_r_ff - 4'd1;
            DIR_LEFT: cur_c_in = cur_c_ff + 4'd1;
            default:  cur_c_in = cur_c_ff - 4'd1;
         endcase
         cur_in = CellW'(cur_r_in) * CellW'(COLS) + CellW'(cur_c_in);
      end
      if (cmd.push_start) len_in = len_ff + 7'd1;
      if (cmd.emit) len_in = len_ff - 7'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         head_ff <= '0;
         tail_ff <= '0;
         len_ff <= '0;
      end else begin
         if (cmd.load) valid_ff <= sok && tok;
         head_ff <= head_in;
         tail_ff <= tail_in;
         len_ff <= len_in;
      end
      visited_ff <= visited_in;
      cur_ff <= cur_in;
      cur_r_ff <= cur_r_in;
      cur_c_ff <= cur_c_in;
      // Parent of the next current cell, so it lines up with cur_ff.
      pdir_ff <= parent_mem[cur_in];
      // Queue head, with the entry being written forwarded when the queue was empty.
      if (cmd.expand && nb_ok && (tail_ff == head_ff)) q_rd_ff <= nb;
      else q_rd_ff <= queue_mem[head_ff[CellW-1:0]];
      if (cmd.load) begin
         start_ff <= start_cell;
         target_ff <= target_cell;
         start_code_ff <= start_code;
         queue_mem[0] <= start_cell;
      end
      if (cmd.expand && nb_ok) begin
         parent_mem[nb] <= cmd.dir;
         queue_mem[tail_ff[CellW-1:0]] <= nb;
      end
      if (cmd.trace) stack_mem[len_ff[CellW-1:0]] <= cur_code;
      if (cmd.push_start) stack_mem[len_ff[CellW-1:0]] <= start_code_ff;
      if (cmd.emit) out_code <= stack_mem[CellW'(len_ff - 7'd1)];
   end

   assign sts.valid_q = valid_ff;
   assign sts.q_empty = (head_ff == tail_ff);
   assign sts.at_target = (cur_ff == target_ff);
   assign sts.at_start = (cur_ff == start_ff);
   assign sts.stack_one = (len_ff == 7'd1);
   assign sts.trace_full = (len_ff >= 7'(MaxCells - 1));

endmodule

// ===== hw/rtl/gbsp_ctrl.sv =====
// Controller of the grid shortest-path block: sequences search, trace-back and
// output beats. Uses gbsp_pkg.
`timescale 1ns / 1ps
module gbsp_ctrl
   import gbsp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output logic    rsp_found,
   output logic    rsp_last,
   output logic    busy,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_CHECK, S_POP, S_TEST, S_EXPAND, S_TRACE, S_EMIT, S_OUT
   } state_type;

   state_type state_ff;
   dir_type   dir_ff;
   logic      out_v_ff, found_ff, last_ff;
   logic      out_load;

   assign req_tready = (state_ff == S_IDLE) && !out_v_ff;
   assign rsp_tvalid = out_v_ff;
   assign rsp_found = found_ff;
   assign rsp_last = last_ff;
   assign busy = (state_ff != S_IDLE) || out_v_ff;

   always_comb begin
      cmd = '0;
      cmd.dir = dir_ff;
      case (state_ff)
         S_IDLE:   cmd.load = req_tvalid && req_tready;
         S_POP:    cmd.pop = !sts.q_empty;
         S_EXPAND: cmd.expand = 1'b1;
         S_TRACE: begin
            cmd.trace = !sts.at_start && !sts.trace_full;
            cmd.push_start = !cmd.trace;
         end
         S_EMIT:   cmd.emit = !out_v_ff || rsp_tready;
         default:  cmd.dir = dir_ff;
      endcase
   end

   // A new beat is loaded on a not-found outcome or on each emitted path cell.
   assign out_load = ((state_ff == S_CHECK) && !sts.valid_q) ||
                     ((state_ff == S_POP) && sts.q_empty) ||
                     ((state_ff == S_EMIT) && cmd.emit);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dir_ff <= DIR_UP;
         out_v_ff <= 1'b0;
         found_ff <= 1'b0;
         last_ff <= 1'b0;
      end else begin
         out_v_ff <= out_load || (out_v_ff && !rsp_tready);
         case (state_ff)
            S_IDLE: if (cmd.load) state_ff <= S_CHECK;
            S_CHECK: begin
               if (sts.valid_q) state_ff <= S_POP;
               else begin
                  found_ff <= 1'b0; last_ff <= 1'b1;
                  state_ff <= S_OUT;
               end
            end
            S_POP: begin
               if (sts.q_empty) begin
                  found_ff <= 1'b0; last_ff <= 1'b1;
                  state_ff <= S_OUT;
               end else state_ff <= S_TEST;
            end
            S_TEST: begin
               dir_ff <= DIR_UP;
               state_ff <= sts.at_target ? S_TRACE : S_EXPAND;
            end
            S_EXPAND: begin
               dir_ff <= dir_type'(dir_ff + 2'd1);
               if (dir_ff == DIR_RIGHT) state_ff <= S_POP;
            end
            S_TRACE: if (cmd.push_start) state_ff <= S_EMIT;
            S_EMIT: begin
               if (cmd.emit) begin
                  found_ff <= 1'b1; last_ff <= sts.stack_one;
                  if (sts.stack_one) state_ff <= S_OUT;
               end
            end
            S_OUT: if (!out_v_ff || rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!out_v_ff || rsp_tready)) else $error("emit over pending beat");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_CHECK) else $error("load did not start query");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (out_v_ff && !last_ff) |-> state_ff == S_EMIT) else $error("stray partial beat");
`endif

endmodule
